// ----- sv/mmu_pkg.sv -----
package mmu_pkg;

    localparam int MAX_DIM    = 8;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int DIM_W      = 4;
    localparam int ELEM_W     = 16;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int SUM_W      = 35;
    localparam int OP_W       = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 48;
    localparam int CFG_ADDR_W = 1;

    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_START  = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_ROWS_A    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_INNER_DIM = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    typedef enum logic [1:0] {
        CMD_LOAD_A,
        CMD_LOAD_B,
        CMD_START
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [ELEM_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0] rows_last;
        logic [IDX_W-1:0] inner_last;
    } dims_t;

    function automatic logic [IDX_W-1:0] clamp_last(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] d;
        begin
            if (v == '0) begin
                d = DIM_W'(1);
            end else if (v > DIM_W'(MAX_DIM)) begin
                d = DIM_W'(MAX_DIM);
            end else begin
                d = v;
            end
            clamp_last = IDX_W'(d - DIM_W'(1));
        end
    endfunction

endpackage

// ----- sv/matrix_multiply_unit.sv -----
// matrix product unit: A (rows_a x inner_dim) times B (inner_dim x inner_dim)
// requests arrive on the s_ channel; tuser carries the operation, tdata the
// row, column and Q8.8 value. load A / load B requests store one element,
// a start request emits every product element on the m_ channel in
// row-major order as a Q19.16 sum, with tlast on the final one.
// rows_a and inner_dim are set through cfg_we / cfg_addr / cfg_wdata; the user
// must write them only while the unit is idle, which the block does not
// enforce; 0 acts as 1 and values above 8 act as 8. a four-entry request
// queue sits between the decoder and the datapath, so requests are taken
// while the datapath works or the output waits. loads retire one per cycle
// while no start is running. one shared multiply-accumulate unit does one
// term per cycle while the output is not stalled: each term passes the read
// and multiply stages into the accumulator, and finished sums into the output register.
// a stall on m_tready freezes the datapath with the result held in the
// output register; the queue keeps taking requests until it fills.
// reset clears the queue and datapath and sets both dimensions to 8;
// matrix contents are undefined until written.
module matrix_multiply_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // row_index[2:0], col_index[5:3], element_value[21:6], zero pad
    input  logic [mmu_pkg::S_DATA_W-1:0]    s_tdata,
    // operation[1:0]
    input  logic [mmu_pkg::OP_W-1:0]        s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_row[2:0], out_col[5:3], product_value[40:6], zero pad
    output logic [mmu_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [mmu_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [mmu_pkg::DIM_W-1:0]       cfg_wdata
);

    logic [mmu_pkg::DIM_W-1:0] rows_a_reg, rows_a_next;
    logic [mmu_pkg::DIM_W-1:0] inner_dim_reg, inner_dim_next;
    mmu_pkg::dims_t            dims;
    mmu_pkg::cmd_t             push_cmd, pop_cmd;
    logic                      push, pop, fifo_full, fifo_empty;

    always_comb begin
        rows_a_next    = rows_a_reg;
        inner_dim_next = inner_dim_reg;
        if (cfg_we) begin
            case (cfg_addr)
                mmu_pkg::REG_ROWS_A:    rows_a_next    = cfg_wdata;
                mmu_pkg::REG_INNER_DIM: inner_dim_next = cfg_wdata;
                default: begin
                end
            endcase
        end
        dims.rows_last  = mmu_pkg::clamp_last(rows_a_reg);
        dims.inner_last = mmu_pkg::clamp_last(inner_dim_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg    <= mmu_pkg::DIM_RESET;
            inner_dim_reg <= mmu_pkg::DIM_RESET;
        end else begin
            rows_a_reg    <= rows_a_next;
            inner_dim_reg <= inner_dim_next;
        end
    end

    mmu_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_full (fifo_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    mmu_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (fifo_empty)
    );

    mmu_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (!fifo_empty),
        .cmd       (pop_cmd),
        .pop       (pop),
        .dims      (dims),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- sv/mmu_front.sv -----
module mmu_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // row_index, col_index, element_value, zero pad
    input  logic [mmu_pkg::S_DATA_W-1:0]  s_tdata,
    // operation
    input  logic [mmu_pkg::OP_W-1:0]      s_tuser,
    input  logic                          fifo_full,
    output logic                          push,
    output mmu_pkg::cmd_t                 push_cmd
);

    logic known_op;

    assign s_tready = !fifo_full;

    always_comb begin
        push_cmd.row   = s_tdata[mmu_pkg::IDX_W-1:0];
        push_cmd.col   = s_tdata[2*mmu_pkg::IDX_W-1:mmu_pkg::IDX_W];
        push_cmd.value = s_tdata[2*mmu_pkg::IDX_W+mmu_pkg::ELEM_W-1:2*mmu_pkg::IDX_W];
        known_op       = 1'b1;
        case (s_tuser)
            mmu_pkg::OP_LOAD_A: begin
                push_cmd.kind = mmu_pkg::CMD_LOAD_A;
            end
            mmu_pkg::OP_LOAD_B: begin
                push_cmd.kind = mmu_pkg::CMD_LOAD_B;
            end
            mmu_pkg::OP_START: begin
                push_cmd.kind = mmu_pkg::CMD_START;
            end
            default: begin
                push_cmd.kind = mmu_pkg::CMD_START;
                known_op      = 1'b0;
            end
        endcase
        push = s_tvalid && s_tready && known_op;
    end

endmodule

// ----- sv/mmu_fifo.sv -----
module mmu_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mmu_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output mmu_pkg::cmd_t pop_cmd,
    output logic          empty
);

    mmu_pkg::cmd_t                    slot_reg [mmu_pkg::FIFO_DEPTH];
    logic [mmu_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [mmu_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [mmu_pkg::FIFO_CNT_W-1:0]   count_reg, count_next;
    logic                             do_push, do_pop;

    assign full    = count_reg == mmu_pkg::FIFO_CNT_W'(mmu_pkg::FIFO_DEPTH);
    assign empty   = count_reg == '0;
    assign pop_cmd = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- sv/mmu_back.sv -----
module mmu_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    input  mmu_pkg::cmd_t                 cmd,
    output logic                          pop,
    input  mmu_pkg::dims_t                dims,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_row, out_col, product_value, zero pad
    output logic [mmu_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tlast
);

    localparam int IW = mmu_pkg::IDX_W;

    logic signed [mmu_pkg::ELEM_W-1:0] mem_a [mmu_pkg::MAX_DIM*mmu_pkg::MAX_DIM];
    logic signed [mmu_pkg::ELEM_W-1:0] mem_b [mmu_pkg::MAX_DIM*mmu_pkg::MAX_DIM];

    logic                 busy_reg, busy_next;
    logic [IW-1:0]        i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic                 en, issue, k_last, j_last, i_last;
    logic                 wr_a, wr_b;
    logic [mmu_pkg::ADDR_W-1:0] waddr, raddr_a, raddr_b;

    // read stage
    logic signed [mmu_pkg::ELEM_W-1:0] a_rd_reg, b_rd_reg;
    logic                 s1_valid_reg, s1_first_reg, s1_lastk_reg, s1_lastel_reg;
    logic [IW-1:0]        s1_i_reg, s1_j_reg;
    // multiply stage
    logic signed [mmu_pkg::PROD_W-1:0] prod_reg;
    logic                 s2_valid_reg, s2_first_reg, s2_lastk_reg, s2_lastel_reg;
    logic [IW-1:0]        s2_i_reg, s2_j_reg;
    // accumulate and output
    logic signed [mmu_pkg::SUM_W-1:0] acc_reg, sum;
    logic                 m_valid_reg, m_valid_next, m_last_reg;
    logic [IW-1:0]        m_row_reg, m_col_reg;
    logic [mmu_pkg::SUM_W-1:0] m_value_reg;

    assign en      = !m_valid_reg || m_tready;
    assign pop     = !busy_reg && cmd_valid;
    assign wr_a    = pop && cmd.kind == mmu_pkg::CMD_LOAD_A;
    assign wr_b    = pop && cmd.kind == mmu_pkg::CMD_LOAD_B;
    assign waddr   = {cmd.row, cmd.col};
    assign raddr_a = {i_reg, k_reg};
    assign raddr_b = {k_reg, j_reg};
    assign issue   = busy_reg && en;
    assign k_last  = k_reg == dims.inner_last;
    assign j_last  = j_reg == dims.inner_last;
    assign i_last  = i_reg == dims.rows_last;

    always_comb begin
        busy_next = busy_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        k_next    = k_reg;
        if (pop && cmd.kind == mmu_pkg::CMD_START) begin
            busy_next = 1'b1;
            i_next    = '0;
            j_next    = '0;
            k_next    = '0;
        end else if (issue) begin
            k_next = k_reg + 1'b1;
            if (k_last) begin
                k_next = '0;
                j_next = j_reg + 1'b1;
                if (j_last) begin
                    j_next = '0;
                    i_next = i_reg + 1'b1;
                    if (i_last) begin
                        busy_next = 1'b0;
                    end
                end
            end
        end
    end

    always_comb begin
        sum = (s2_first_reg ? '0 : acc_reg)
            + {{(mmu_pkg::SUM_W-mmu_pkg::PROD_W){prod_reg[mmu_pkg::PROD_W-1]}}, prod_reg};
        m_valid_next = m_valid_reg && !m_tready;
        if (en) begin
            m_valid_next = s2_valid_reg && s2_lastk_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
            if (en) begin
                s1_valid_reg <= issue;
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_a) begin
            mem_a[waddr] <= cmd.value;
        end
        if (wr_b) begin
            mem_b[waddr] <= cmd.value;
        end
        if (en) begin
            a_rd_reg <= mem_a[raddr_a];
            b_rd_reg <= mem_b[raddr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_first_reg  <= k_reg == '0;
            s1_lastk_reg  <= k_last;
            s1_lastel_reg <= k_last && j_last && i_last;
            s1_i_reg      <= i_reg;
            s1_j_reg      <= j_reg;
            prod_reg      <= a_rd_reg * b_rd_reg;
            s2_first_reg  <= s1_first_reg;
            s2_lastk_reg  <= s1_lastk_reg;
            s2_lastel_reg <= s1_lastel_reg;
            s2_i_reg      <= s1_i_reg;
            s2_j_reg      <= s1_j_reg;
            if (s2_valid_reg) begin
                acc_reg <= sum;
            end
            if (s2_valid_reg && s2_lastk_reg) begin
                m_row_reg   <= s2_i_reg;
                m_col_reg   <= s2_j_reg;
                m_value_reg <= sum;
                m_last_reg  <= s2_lastel_reg;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(mmu_pkg::M_DATA_W-mmu_pkg::SUM_W-2*IW){1'b0}},
                       m_value_reg, m_col_reg, m_row_reg};

endmodule

// ----- bench/matrix_multiply_unit_tb.sv -----
module matrix_multiply_unit_tb;

    localparam logic [mmu_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 20;
    localparam int DRAIN_CYCLES = 30;
    localparam int LONG_HOLD    = 200;

    typedef struct packed {
        logic [mmu_pkg::IDX_W-1:0]         row;
        logic [mmu_pkg::IDX_W-1:0]         col;
        logic signed [mmu_pkg::SUM_W-1:0]  value;
        logic                              last;
    } product_t;

    class product_checker;
        logic signed [mmu_pkg::ELEM_W-1:0] a_elem [mmu_pkg::MAX_DIM*mmu_pkg::MAX_DIM];
        logic signed [mmu_pkg::ELEM_W-1:0] b_elem [mmu_pkg::MAX_DIM*mmu_pkg::MAX_DIM];
        bit a_seen [mmu_pkg::MAX_DIM*mmu_pkg::MAX_DIM];
        bit b_seen [mmu_pkg::MAX_DIM*mmu_pkg::MAX_DIM];
        logic [mmu_pkg::DIM_W-1:0] rows_reg;
        logic [mmu_pkg::DIM_W-1:0] inner_reg;
        product_t pending_products [$];
        int errors;

        function new();
            rows_reg = mmu_pkg::DIM_RESET;
            inner_reg = mmu_pkg::DIM_RESET;
            errors = 0;
            foreach (a_seen[n]) begin
                a_seen[n] = 1'b0;
                b_seen[n] = 1'b0;
            end
        endfunction

        function int dim_of(logic [mmu_pkg::DIM_W-1:0] v);
            if (v == '0) return 1;
            if (v > mmu_pkg::DIM_W'(mmu_pkg::MAX_DIM)) return mmu_pkg::MAX_DIM;
            return int'(v);
        endfunction

        function int pending();
            return pending_products.size();
        endfunction

        function void predict_request(logic [mmu_pkg::OP_W-1:0] op,
                                      logic [mmu_pkg::IDX_W-1:0] r,
                                      logic [mmu_pkg::IDX_W-1:0] c,
                                      logic signed [mmu_pkg::ELEM_W-1:0] v);
            int nr, nd, i, j, k;
            longint acc;
            product_t p;
            nr = dim_of(rows_reg);
            nd = dim_of(inner_reg);
            case (op)
                mmu_pkg::OP_LOAD_A: begin
                    a_elem[r * mmu_pkg::MAX_DIM + c] = v;
                    a_seen[r * mmu_pkg::MAX_DIM + c] = 1'b1;
                end
                mmu_pkg::OP_LOAD_B: begin
                    b_elem[r * mmu_pkg::MAX_DIM + c] = v;
                    b_seen[r * mmu_pkg::MAX_DIM + c] = 1'b1;
                end
                mmu_pkg::OP_START: begin
                    for (i = 0; i < nr; i++) begin
                        for (j = 0; j < nd; j++) begin
                            acc = 0;
                            for (k = 0; k < nd; k++) begin
                                acc += longint'(a_elem[i * mmu_pkg::MAX_DIM + k])
                                     * longint'(b_elem[k * mmu_pkg::MAX_DIM + j]);
                            end
                            p.row = mmu_pkg::IDX_W'(i);
                            p.col = mmu_pkg::IDX_W'(j);
                            p.value = acc[mmu_pkg::SUM_W-1:0];
                            p.last = (i == nr - 1) && (j == nd - 1);
                            pending_products.push_back(p);
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_product(logic [mmu_pkg::M_DATA_W-1:0] data, logic last);
            product_t want;
            if (pending_products.size() == 0) begin
                errors++;
                $display("%0t: no product expected, actual tdata %h tlast %b",
                         $time, data, last);
                return;
            end
            want = pending_products.pop_front();
            compare_field("out_row", want.row, data[2:0]);
            compare_field("out_col", want.col, data[5:3]);
            compare_field("product_value", longint'(want.value),
                          longint'($signed(data[40:6])));
            compare_field("last", want.last, last);
        endfunction
    endclass

    logic                               aclk;
    logic                               aresetn;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [mmu_pkg::S_DATA_W-1:0]       s_tdata;
    logic [mmu_pkg::OP_W-1:0]           s_tuser;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [mmu_pkg::M_DATA_W-1:0]       m_tdata;
    logic                               m_tlast;
    logic                               cfg_we;
    logic [mmu_pkg::CFG_ADDR_W-1:0]     cfg_addr;
    logic [mmu_pkg::DIM_W-1:0]          cfg_wdata;

    product_checker sb = new();
    int  sent_items = 0;
    int  stall_request = 0;
    bit  calm = 1'b0;

    matrix_multiply_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #800000;
        $display("matrix_multiply_unit_tb: errors");
        $finish;
    end

    // result side: random back-pressure plus an occasional long hold
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_request > 0) begin
                hold_left = stall_request;
                stall_request = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 34);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_product(m_tdata, m_tlast);
        end
    end

    function automatic logic [mmu_pkg::ELEM_W-1:0] elem_value();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0000;
            default: return mmu_pkg::ELEM_W'($urandom);
        endcase
    endfunction

    task automatic send_request(input logic [mmu_pkg::OP_W-1:0] op,
                                input logic [mmu_pkg::IDX_W-1:0] r,
                                input logic [mmu_pkg::IDX_W-1:0] c,
                                input logic [mmu_pkg::ELEM_W-1:0] v);
        while (!calm && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {2'b00, v, c, r};
        do @(posedge aclk); while (!s_tready);
        sb.predict_request(op, r, c, v);
        if (op != OP_UNUSED) sent_items++;
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_dims(input logic [mmu_pkg::DIM_W-1:0] r,
                            input logic [mmu_pkg::DIM_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_addr <= mmu_pkg::REG_ROWS_A;
        cfg_wdata <= r;
        @(posedge aclk);
        sb.rows_reg = r;
        cfg_addr <= mmu_pkg::REG_INNER_DIM;
        cfg_wdata <= d;
        @(posedge aclk);
        sb.inner_reg = d;
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_start();
        send_request(mmu_pkg::OP_START, mmu_pkg::IDX_W'($urandom),
                     mmu_pkg::IDX_W'($urandom), mmu_pkg::ELEM_W'($urandom));
    endtask

    // write every element that the current dimensions read but nobody wrote yet
    task automatic load_missing();
        int nr, nd, i, j;
        nr = sb.dim_of(sb.rows_reg);
        nd = sb.dim_of(sb.inner_reg);
        for (i = 0; i < nr; i++) begin
            for (j = 0; j < nd; j++) begin
                if (!sb.a_seen[i * mmu_pkg::MAX_DIM + j]) begin
                    send_request(mmu_pkg::OP_LOAD_A, mmu_pkg::IDX_W'(i),
                                 mmu_pkg::IDX_W'(j), elem_value());
                end
            end
        end
        for (i = 0; i < nd; i++) begin
            for (j = 0; j < nd; j++) begin
                if (!sb.b_seen[i * mmu_pkg::MAX_DIM + j]) begin
                    send_request(mmu_pkg::OP_LOAD_B, mmu_pkg::IDX_W'(i),
                                 mmu_pkg::IDX_W'(j), elem_value());
                end
            end
        end
    endtask

    task automatic run_product(input int n_loads, input bit with_start);
        int n;
        for (n = 0; n < n_loads; n++) begin
            if ($urandom_range(9) == 0) begin
                send_request(OP_UNUSED, mmu_pkg::IDX_W'($urandom),
                             mmu_pkg::IDX_W'($urandom), elem_value());
            end
            send_request($urandom_range(1) ? mmu_pkg::OP_LOAD_B : mmu_pkg::OP_LOAD_A,
                         mmu_pkg::IDX_W'($urandom), mmu_pkg::IDX_W'($urandom),
                         elem_value());
        end
        load_missing();
        if (with_start) send_start();
    endtask

    initial begin
        int i, j, phase, base;
        logic [mmu_pkg::DIM_W-1:0] r, d;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: single element products at the value extremes
        set_dims(4'd1, 4'd1);
        send_request(mmu_pkg::OP_LOAD_A, 3'd0, 3'd0, 16'h8000);
        send_request(mmu_pkg::OP_LOAD_B, 3'd0, 3'd0, 16'h8000);
        send_start();
        send_request(mmu_pkg::OP_LOAD_A, 3'd0, 3'd0, 16'h7fff);
        send_start();
        send_request(OP_UNUSED, 3'd7, 3'd7, 16'h1234);
        // stored outside the active dimensions, must not change the product
        send_request(mmu_pkg::OP_LOAD_A, 3'd7, 3'd7, 16'h7fff);
        send_request(mmu_pkg::OP_LOAD_B, 3'd7, 3'd7, 16'hffff);
        send_start();
        wait_drain();
        set_dims(4'd0, 4'd0);
        send_request(mmu_pkg::OP_LOAD_B, 3'd0, 3'd0, 16'h0001);
        send_start();
        wait_drain();
        set_dims(4'd2, 4'd3);
        run_product(0, 1'b1);
        send_start();

        // full inner size: column 0 gives the largest sum, column 1 the smallest
        wait_drain();
        set_dims(4'd1, 4'd9);
        for (j = 0; j < mmu_pkg::MAX_DIM; j++) begin
            send_request(mmu_pkg::OP_LOAD_A, 3'd0, mmu_pkg::IDX_W'(j), 16'h8000);
        end
        for (i = 0; i < mmu_pkg::MAX_DIM; i++) begin
            for (j = 0; j < mmu_pkg::MAX_DIM; j++) begin
                send_request(mmu_pkg::OP_LOAD_B, mmu_pkg::IDX_W'(i), mmu_pkg::IDX_W'(j),
                             (j == 0) ? 16'h8000 : (j == 1) ? 16'h7fff : elem_value());
            end
        end
        send_start();
        stall_request = LONG_HOLD;
        send_start();
        run_product(6, 1'b1);

        // random phases, small row counts
        base = sent_items;
        phase = 0;
        while (sent_items < base + RANDOM_ITEMS) begin
            wait_drain();
            r = mmu_pkg::DIM_W'($urandom_range(2));
            d = ($urandom_range(5) == 0) ? mmu_pkg::DIM_W'($urandom_range(15))
                                         : mmu_pkg::DIM_W'($urandom_range(1, 4));
            set_dims(r, d);
            calm = (phase == 0);
            repeat (3) begin
                run_product(calm ? 6 : $urandom_range(6), $urandom_range(9) != 0);
                if ($urandom_range(3) == 0) wait_drain();
            end
            phase++;
        end
        calm = 1'b0;

        wait_drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("matrix_multiply_unit_tb: clean");
        end else begin
            $display("matrix_multiply_unit_tb: errors");
        end
        $finish;
    end

endmodule
